// File: rtl/core/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Shared widths, control types and calendar helpers for the date advance block.
// ----------------------------------------------------------------------------
package dad_pkg;

    // field widths
    localparam int DayW   = 5;
    localparam int MonW   = 4;
    localparam int YearW  = 16;
    localparam int CntW   = 16;
    // days to month rollover: up to 32 (day 0 in a 31-day month)
    localparam int StepW  = 6;

    // packed stream words
    localparam int InFldW     = DayW + MonW + YearW + CntW;
    localparam int InTdataW   = ((InFldW + 7) / 8) * 8;
    localparam int OutFldW    = DayW + MonW + YearW;
    localparam int OutTdataW  = ((OutFldW + 7) / 8) * 8;

    // month numbers used by the rollover logic
    localparam logic [MonW-1:0] MON_FEB = 4'd2;
    localparam logic [MonW-1:0] MON_APR = 4'd4;
    localparam logic [MonW-1:0] MON_JUN = 4'd6;
    localparam logic [MonW-1:0] MON_SEP = 4'd9;
    localparam logic [MonW-1:0] MON_NOV = 4'd11;
    localparam logic [MonW-1:0] MON_DEC = 4'd12;

    // divisibility by 25: y * inv(25) mod 2^16 stays at or below 65535/25
    localparam logic [YearW-1:0] INV25     = 16'd23593;
    localparam logic [YearW-1:0] DIV25_MAX = 16'd2621;

    // controller -> datapath
    typedef struct packed {
        logic load;   // take a new word from the input
        logic step;   // advance by one month or finish the count
        logic store;  // copy the date into the output register
    } t_dad_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;   // remaining count is zero
    } t_dad_sts;

    // Gregorian leap rule; year 0 counts as leap
    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [YearW-1:0] prod;
        logic             by25;
        prod = y * INV25;
        by25 = (prod <= DIV25_MAX);
        return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
    endfunction

    // month length; months outside 1..12 run 31 days
    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        unique case (m)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/core/date_add_days.sv
// ----------------------------------------------------------------------------
// date_add_days
// Gregorian date advance by an unsigned day count.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one word: start date and day count.
//   Master channel (m_*) returns one word: the date that many days later.
//   Month rollover follows the Gregorian leap rule; the year wraps at 65536.
// Sequence:
//   The accepting edge loads the word; then one step per month end crossed,
//   one step for the days left in the last month (none when the count ends
//   on day 1) and a store, which waits until an earlier result is taken.
//   The month-step unit sets the number of steps: about add_count/30.4.
// Flow:
//   One word in flight; the input opens the cycle after the store, so a held
//   result does not stop the next word.
// Stall:
//   A finished result waits in the output register; a second finished
//   result waits in the datapath until the first is taken.
// Reset:
//   Synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module date_add_days
    import dad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tdata: start_day[4:0], start_month[8:5], start_year[24:9],
    //        add_count[40:25], zero fill [47:41]
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [InTdataW-1:0]  i_s_tdata,
    // tdata: new_day[4:0], new_month[8:5], new_year[24:9], zero fill [31:25]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OutTdataW-1:0] o_m_tdata
);

    t_dad_cmd cmd;
    t_dad_sts sts;

    // sequencer
    dad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // date registers and month-step unit
    dad_dpath u_dpath (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_word (i_s_tdata),
        .o_word (o_m_tdata),
        .o_sts  (sts)
    );

endmodule

// File: rtl/core/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer: takes a word, steps the datapath until the count is spent, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module dad_ctrl
    import dad_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    output t_dad_cmd o_cmd,
    input  t_dad_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.done) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.store = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/core/dad_dpath.sv
// ----------------------------------------------------------------------------
// dad_dpath
// Date registers and the month-step unit: each step either spends the days
// left in the current month and rolls over, or adds the remaining count.
// ----------------------------------------------------------------------------
module dad_dpath
    import dad_pkg::*;
(
    input  logic                 i_clk,
    input  t_dad_cmd             i_cmd,
    input  logic [InTdataW-1:0]  i_word,
    output logic [OutTdataW-1:0] o_word,
    output t_dad_sts             o_sts
);

    logic [DayW-1:0]  r_day,   n_day;
    logic [MonW-1:0]  r_month, n_month;
    logic [YearW-1:0] r_year,  n_year;
    logic [CntW-1:0]  r_count, n_count;
    logic             r_leap,  n_leap;
    logic [OutFldW-1:0] r_out;

    logic [DayW-1:0]  len;
    logic [StepW-1:0] to_roll;
    logic             roll;
    logic [YearW-1:0] year_inc;

    // days needed to reach day 1 of the next month
    always_comb begin
        len = month_len(r_month, r_leap);
        if (r_day > len) begin
            to_roll = StepW'(1);
        end else begin
            to_roll = StepW'(len) - StepW'(r_day) + StepW'(1);
        end
        roll     = (r_count >= CntW'(to_roll));
        year_inc = r_year + YearW'(1);
    end

    // next date
    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_count = r_count;
        n_leap  = r_leap;
        if (i_cmd.load) begin
            n_day   = i_word[DayW-1:0];
            n_month = i_word[DayW +: MonW];
            n_year  = i_word[DayW+MonW +: YearW];
            n_count = i_word[DayW+MonW+YearW +: CntW];
            n_leap  = is_leap(i_word[DayW+MonW +: YearW]);
        end else if (i_cmd.step) begin
            if (roll) begin
                n_count = r_count - CntW'(to_roll);
                n_day   = DayW'(1);
                if (r_month >= MON_DEC) begin
                    n_month = MonW'(1);
                    n_year  = year_inc;
                    n_leap  = is_leap(year_inc);
                end else begin
                    n_month = r_month + MonW'(1);
                end
            end else begin
                // count is below the days to rollover, so it fits a day field
                n_day   = r_day + r_count[DayW-1:0];
                n_count = '0;
            end
        end
    end

    // working and output registers
    always_ff @(posedge i_clk) begin
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_count <= n_count;
        r_leap  <= n_leap;
        if (i_cmd.store) begin
            r_out <= {r_year, r_month, r_day};
        end
    end

    assign o_sts.done = (r_count == '0);
    assign o_word     = {{(OutTdataW-OutFldW){1'b0}}, r_out};

endmodule

// File: rtl/core/dad_checker.sv
// ----------------------------------------------------------------------------
// dad_checker
// Port-level checks for the date advance block, bound to the top level.
// ----------------------------------------------------------------------------
module dad_checker
    import dad_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [InTdataW-1:0]  i_s_tdata,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [OutTdataW-1:0] o_m_tdata
);

    // a held result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    // a held result keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: input closes after a take
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input open right after a take");

    // zero count taken with no result held returns the start date after the load and the store
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tdata[40:25] == 16'd0) && !o_m_tvalid
        |=> ##1 o_m_tvalid && (o_m_tdata[24:0] == $past(i_s_tdata[24:0], 2)))
        else $error("zero count did not return the start date");

endmodule

bind date_add_days dad_checker u_dad_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
